// ----- design/pspc_pkg.sv -----
package pspc_pkg;

  // Table geometry default
  localparam int TABLE_ENTRIES_DEF = 64;

  // Field widths
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int RIDX_W     = 6;
  localparam int EIDX_W     = 6;
  localparam int USED_W     = 7;

  // One table entry in memory: {count, address}
  localparam int ENTRY_W    = ADDR_W + COUNT_W;

  // Stream word widths
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 80;
  localparam int M_TUSER_W  = 4;

  // Operation codes carried in s_tuser
  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ----- design/pspc_ram.sv -----
module pspc_ram #(
  parameter int WIDTH = pspc_pkg::ENTRY_W,
  parameter int DEPTH = pspc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read that holds when not enabled
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/per_source_packet_counter_top.sv -----
// Per-source packet counter: a table of up to TABLE_ENTRIES IPv4 source
// addresses, each with a saturating 32-bit packet count, held in one
// single-port-read RAM of {count, address} entries. A count word (tuser 0)
// searches the used entries from entry 0, one entry per cycle through the RAM
// read port, then bumps the hit entry or appends a new one. Every input word
// gives exactly one result word. A finished result waits in the output
// register while the next input word is taken. A stalled output holds the
// block in its last step until the register frees. A nonzero capture_limit
// stops counting once that many packets have been taken; counting words after
// that give a result with zero index, address and count, but the current
// used count, with capture_stopped set. Write cfg only while the block is idle.
module per_source_packet_counter_top #(
  parameter int TABLE_ENTRIES = pspc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // config: capture_limit
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pspc_pkg::COUNT_W-1:0]   cfg_data,
  // s_tdata: source_address[31:0], read_index[37:32], zero pad
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [pspc_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: op[0]
  input  logic                           s_tuser,
  // m_tdata: entry_index[5:0], entry_address[37:6], entry_count[69:38],
  //          used_count[76:70], zero pad
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [pspc_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: new_entry[0], table_full[1], capture_stopped[2], entry_valid[3]
  output logic [pspc_pkg::M_TUSER_W-1:0] m_tuser
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > pspc_pkg::RIDX_W) ? CNT_W : pspc_pkg::RIDX_W;
  localparam int AW    = pspc_pkg::ADDR_W;
  localparam int CW    = pspc_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_STOP   = 2'd3;

  logic [1:0]                    state, state_next;
  logic [IDX_W-1:0]              k, k_next;
  logic [AW-1:0]                 addr_r, addr_r_next;
  logic [pspc_pkg::RIDX_W-1:0]   ridx, ridx_next;
  logic [CNT_W-1:0]              used, used_next;
  logic [CW-1:0]                 seen, seen_next;
  logic [CW-1:0]                 limit;
  logic                          m_tvalid_next;
  logic [pspc_pkg::M_TDATA_W-1:0] m_tdata_next;
  logic [pspc_pkg::M_TUSER_W-1:0] m_tuser_next;

  // RAM port signals
  logic                          ram_we, ram_re;
  logic [IDX_W-1:0]              ram_waddr, ram_raddr;
  logic [pspc_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // Derived conditions
  logic                          out_free;
  logic                          limit_hit;
  logic [AW-1:0]                 rd_addr;
  logic [CW-1:0]                 rd_count, rd_count_inc;
  logic                          hit;
  logic                          more;
  logic                          rd_ok;
  logic                          room;

  // Result fields before packing
  logic [pspc_pkg::EIDX_W-1:0]   o_idx;
  logic [AW-1:0]                 o_addr;
  logic [CW-1:0]                 o_count;
  logic                          o_new, o_full, o_valid;
  logic [CNT_W-1:0]              o_used;
  logic                          o_load;

  pspc_ram #(
    .WIDTH (pspc_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign limit_hit = (limit != '0) && (seen >= limit);

  // Entry under test
  assign rd_addr      = ram_rdata[AW-1:0];
  assign rd_count     = ram_rdata[pspc_pkg::ENTRY_W-1:AW];
  assign rd_count_inc = (rd_count == pspc_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;
  assign hit   = (CNT_W'(k) < used) && (rd_addr == addr_r);
  assign more  = (CNT_W'(k) + 1'b1) < used;
  assign room  = used != CNT_W'(TABLE_ENTRIES);
  assign rd_ok = CMP_W'(ridx) < CMP_W'(used);

  // Sequencer and result selection
  always_comb begin
    state_next    = state;
    k_next        = k;
    addr_r_next   = addr_r;
    ridx_next     = ridx;
    used_next     = used;
    seen_next     = seen;
    m_tvalid_next = m_tvalid && !m_tready;
    ram_we        = 1'b0;
    ram_waddr     = k;
    ram_wdata     = {rd_count_inc, addr_r};
    ram_re        = 1'b0;
    ram_raddr     = '0;
    o_load        = 1'b0;
    o_idx         = '0;
    o_addr        = '0;
    o_count       = '0;
    o_new         = 1'b0;
    o_full        = 1'b0;
    o_valid       = 1'b0;
    o_used        = used;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          addr_r_next = s_tdata[AW-1:0];
          ridx_next   = s_tdata[AW +: pspc_pkg::RIDX_W];
          if (s_tuser == pspc_pkg::OP_READ) begin
            ram_re     = 1'b1;
            ram_raddr  = IDX_W'(s_tdata[AW +: pspc_pkg::RIDX_W]);
            state_next = ST_RDWAIT;
          end else if (limit_hit) begin
            state_next = ST_STOP;
          end else begin
            if (seen != pspc_pkg::COUNT_MAX) begin
              seen_next = seen + 1'b1;
            end
            ram_re     = 1'b1;
            ram_raddr  = '0;
            k_next     = '0;
            state_next = ST_SEARCH;
          end
        end
      end

      ST_SEARCH: begin
        if (hit) begin
          if (out_free) begin
            ram_we     = 1'b1;
            o_load     = 1'b1;
            o_idx      = pspc_pkg::EIDX_W'(k);
            o_addr     = addr_r;
            o_count    = rd_count_inc;
            o_valid    = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (more) begin
          // next entry, one read per cycle
          ram_re     = 1'b1;
          ram_raddr  = k + 1'b1;
          k_next     = k + 1'b1;
        end else if (out_free) begin
          o_load     = 1'b1;
          state_next = ST_IDLE;
          if (room) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(used);
            ram_wdata = {CW'(1), addr_r};
            used_next = used + 1'b1;
            o_idx     = pspc_pkg::EIDX_W'(used);
            o_addr    = addr_r;
            o_count   = CW'(1);
            o_new     = 1'b1;
            o_valid   = 1'b1;
            o_used    = used + 1'b1;
          end else begin
            o_full = 1'b1;
          end
        end
      end

      ST_RDWAIT: begin
        if (out_free) begin
          o_load     = 1'b1;
          o_idx      = ridx;
          o_valid    = rd_ok;
          o_addr     = rd_ok ? rd_addr : '0;
          o_count    = rd_ok ? rd_count : '0;
          state_next = ST_IDLE;
        end
      end

      ST_STOP: begin
        if (out_free) begin
          o_load     = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Output register load
    m_tdata_next = m_tdata;
    m_tuser_next = m_tuser;
    if (o_load) begin
      m_tvalid_next = 1'b1;
      m_tdata_next  = {3'b000, pspc_pkg::USED_W'(o_used), o_count, o_addr, o_idx};
      m_tuser_next  = {o_valid, limit_hit, o_full, o_new};
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      used     <= '0;
      seen     <= '0;
      limit    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      used     <= used_next;
      seen     <= seen_next;
      m_tvalid <= m_tvalid_next;
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k       <= k_next;
    addr_r  <= addr_r_next;
    ridx    <= ridx_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
  end

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(used) <= CNT_W'(TABLE_ENTRIES))
    else $error("entries used beyond table size");

  a_used_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && used != $past(used)) |-> used == $past(used) + 1'b1)
    else $error("entries used moved by more than one");

  a_write_in_search: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_SEARCH)
    else $error("table written outside search");

  a_new_is_valid: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tuser[3] && !m_tuser[1]))
    else $error("new entry result not valid or marked full");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[3]) |-> m_tdata[69:38] != '0)
    else $error("valid entry with zero count");
`endif

endmodule
